FILE: rtl/imupf_pkg.sv
// ----------------------------------------------------------------------------
// imupf_pkg
// Types and constants shared by the packet field parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package imupf_pkg;

	localparam logic [15:0] ID_EULER   = 16'h2030;
	localparam logic [15:0] ID_ACCEL   = 16'h4020;
	localparam logic [15:0] ID_FREEACC = 16'h4030;
	localparam logic [15:0] ID_GYRO    = 16'h8020;
	localparam logic [7:0]  VEC_LEN    = 8'd12;
	localparam logic [30:0] YAW_WRAP_MAG = 31'h43B4_0000;
	localparam logic [31:0] NEG_ZERO   = 32'h8000_0000;
	localparam logic [7:0]  EXP_MAX    = 8'hFF;
	localparam int          SUM_W      = 27;
	localparam int          LZ_W       = 5;

	typedef enum logic [1:0] {
		KIND_EULER   = 2'd0,
		KIND_ACCEL   = 2'd1,
		KIND_FREEACC = 2'd2,
		KIND_GYRO    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		HP_IDLE,
		HP_H1,
		HP_H2,
		HP_H3,
		HP_PAYLOAD
	} hdr_pos_t;

	typedef enum logic [1:0] {
		PH_ID_HI,
		PH_ID_LO,
		PH_LEN,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_t;

	typedef struct packed {
		logic [1:0]  vector_kind;
		logic [31:0] value_x;
		logic [31:0] value_y;
		logic [31:0] value_z;
	} out_t;

	typedef struct packed {
		out_t res;
		logic wrap;
	} parse_t;

	typedef struct packed {
		out_t             res;
		logic             wrap;
		logic             sign;
		logic [7:0]       exp;
		logic [SUM_W-1:0] diff;
	} align_t;

endpackage

`default_nettype wire

FILE: rtl/imupf_parser.sv
// ----------------------------------------------------------------------------
// imupf_parser
// Byte state machine that walks the packet and registers finished vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module imupf_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire                  adv,
	input  imupf_pkg::in_t       byte_in,
	output logic                 valid_s1,
	output imupf_pkg::parse_t    data_s1
);

	imupf_pkg::hdr_pos_t hp_q, hp_d;
	imupf_pkg::phase_t   ph_q, ph_d;
	logic [7:0]  rem_q, rem_d;
	logic [15:0] id_q, id_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  seen_q, seen_d;
	logic [31:0] comp_q [3];
	logic        wr_en;
	logic [1:0]  wr_idx;
	logic        emit;
	logic        kind_ok;
	logic [1:0]  kind;
	logic [7:0]  b;
	imupf_pkg::parse_t res;

	assign b = byte_in.data_byte;

	always_comb begin
		kind_ok = 1'b1;
		kind = imupf_pkg::KIND_EULER;
		unique case (id_q)
			imupf_pkg::ID_EULER:   kind = imupf_pkg::KIND_EULER;
			imupf_pkg::ID_ACCEL:   kind = imupf_pkg::KIND_ACCEL;
			imupf_pkg::ID_FREEACC: kind = imupf_pkg::KIND_FREEACC;
			imupf_pkg::ID_GYRO:    kind = imupf_pkg::KIND_GYRO;
			default:               kind_ok = 1'b0;
		endcase
	end

	always_comb begin
		hp_d = hp_q;
		ph_d = ph_q;
		rem_d = rem_q;
		id_d = id_q;
		len_d = len_q;
		seen_d = seen_q;
		wr_en = 1'b0;
		wr_idx = seen_q[3:2];
		emit = 1'b0;
		if (accept) begin
			if (byte_in.frame_start) begin
				hp_d = imupf_pkg::HP_H1;
				ph_d = imupf_pkg::PH_ID_HI;
			end else begin
				unique case (hp_q)
					imupf_pkg::HP_H1: hp_d = imupf_pkg::HP_H2;
					imupf_pkg::HP_H2: hp_d = imupf_pkg::HP_H3;
					imupf_pkg::HP_H3: begin
						rem_d = b;
						ph_d = imupf_pkg::PH_ID_HI;
						id_d = '0;
						len_d = '0;
						seen_d = '0;
						hp_d = (b != 8'd0) ? imupf_pkg::HP_PAYLOAD : imupf_pkg::HP_IDLE;
					end
					imupf_pkg::HP_PAYLOAD: begin
						rem_d = rem_q - 8'd1;
						unique case (ph_q)
							imupf_pkg::PH_ID_HI: begin
								id_d = {b, 8'd0};
								ph_d = imupf_pkg::PH_ID_LO;
							end
							imupf_pkg::PH_ID_LO: begin
								id_d = {id_q[15:8], b};
								ph_d = imupf_pkg::PH_LEN;
							end
							imupf_pkg::PH_LEN: begin
								len_d = b;
								seen_d = '0;
								ph_d = (b == 8'd0) ? imupf_pkg::PH_ID_HI : imupf_pkg::PH_DATA;
							end
							imupf_pkg::PH_DATA: begin
								wr_en = (seen_q < imupf_pkg::VEC_LEN);
								seen_d = seen_q + 8'd1;
								if (seen_d == len_q) begin
									emit = kind_ok && (len_q == imupf_pkg::VEC_LEN);
									ph_d = imupf_pkg::PH_ID_HI;
								end
							end
						endcase
						if (rem_d == 8'd0) begin
							hp_d = imupf_pkg::HP_IDLE;
							ph_d = imupf_pkg::PH_ID_HI;
						end
					end
					default: hp_d = imupf_pkg::HP_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		res.res.vector_kind = kind;
		res.res.value_x = comp_q[0];
		res.res.value_y = comp_q[1];
		res.res.value_z = {comp_q[2][23:0], b};
		res.wrap = (kind == imupf_pkg::KIND_EULER) && res.res.value_z[31]
			&& (res.res.value_z != imupf_pkg::NEG_ZERO)
			&& (res.res.value_z[30:23] != imupf_pkg::EXP_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= imupf_pkg::HP_IDLE;
			ph_q <= imupf_pkg::PH_ID_HI;
			rem_q <= '0;
			id_q <= '0;
			len_q <= '0;
			seen_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			hp_q <= hp_d;
			ph_q <= ph_d;
			rem_q <= rem_d;
			id_q <= id_d;
			len_q <= len_d;
			seen_q <= seen_d;
			if (adv) begin
				valid_s1 <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			comp_q[wr_idx] <= {comp_q[wr_idx][23:0], b};
		end
		if (adv) begin
			data_s1 <= res;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/imupf_yaw_align.sv
// ----------------------------------------------------------------------------
// imupf_yaw_align
// First half of the yaw wrap: operand ordering, alignment and subtraction.
// ----------------------------------------------------------------------------
`default_nettype none

module imupf_yaw_align (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 adv,
	input  wire                 valid_s1,
	input  imupf_pkg::parse_t   data_s1,
	output logic                valid_s2,
	output imupf_pkg::align_t   data_s2
);

	localparam int EXT_W = 2 * imupf_pkg::SUM_W;

	logic [31:0] z;
	logic        gt;
	logic [23:0] sig_a, sig_w, big_sig, sm_sig;
	logic [7:0]  e_a, e_w, big_e, sm_e, d;
	logic [imupf_pkg::LZ_W-1:0] dc;
	logic [EXT_W-1:0] ext;
	logic [imupf_pkg::SUM_W-1:0] sm27;
	imupf_pkg::align_t nxt;

	always_comb begin
		z = data_s1.res.value_z;
		gt = z[30:0] > imupf_pkg::YAW_WRAP_MAG;
		sig_a = {(z[30:23] != 8'd0), z[22:0]};
		e_a = (z[30:23] == 8'd0) ? 8'd1 : z[30:23];
		sig_w = {1'b1, imupf_pkg::YAW_WRAP_MAG[22:0]};
		e_w = imupf_pkg::YAW_WRAP_MAG[30:23];
		big_sig = gt ? sig_a : sig_w;
		big_e = gt ? e_a : e_w;
		sm_sig = gt ? sig_w : sig_a;
		sm_e = gt ? e_w : e_a;
		d = big_e - sm_e;
		dc = (d > 8'(imupf_pkg::SUM_W)) ? imupf_pkg::LZ_W'(imupf_pkg::SUM_W)
			: d[imupf_pkg::LZ_W-1:0];
		ext = {sm_sig, 3'b000, {imupf_pkg::SUM_W{1'b0}}} >> dc;
		sm27 = {ext[EXT_W-1:imupf_pkg::SUM_W+1],
			ext[imupf_pkg::SUM_W] | (|ext[imupf_pkg::SUM_W-1:0])};
		nxt.res = data_s1.res;
		nxt.wrap = data_s1.wrap;
		nxt.sign = gt;
		nxt.exp = big_e;
		nxt.diff = {big_sig, 3'b000} - sm27;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/imupf_yaw_round.sv
// ----------------------------------------------------------------------------
// imupf_yaw_round
// Second half of the yaw wrap: normalization, rounding and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imupf_yaw_round (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 adv,
	input  wire                 valid_s2,
	input  imupf_pkg::align_t   data_s2,
	output logic                valid_q,
	output imupf_pkg::out_t     data_q
);

	logic [imupf_pkg::LZ_W-1:0]  lz;
	logic [imupf_pkg::SUM_W-1:0] norm;
	logic        rnd;
	logic [30:0] mag;
	imupf_pkg::out_t nxt;

	always_comb begin
		lz = '0;
		for (int i = 0; i < imupf_pkg::SUM_W; i++) begin
			if (data_s2.diff[i]) begin
				lz = imupf_pkg::LZ_W'(imupf_pkg::SUM_W - 1 - i);
			end
		end
		norm = data_s2.diff << lz;
		rnd = norm[2] & (norm[1] | norm[0] | norm[3]);
		mag = {data_s2.exp - 8'(lz), norm[imupf_pkg::SUM_W-2:3]} + 31'(rnd);
		nxt = data_s2.res;
		if (data_s2.wrap) begin
			if (data_s2.diff == '0) begin
				nxt.value_z = '0;
			end else begin
				nxt.value_z = {data_s2.sign, mag};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nxt;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/imu_packet_field_parser.sv
// ----------------------------------------------------------------------------
// imu_packet_field_parser
// Parses a sensor packet byte stream and emits three-component float vectors.
// ----------------------------------------------------------------------------
// One byte is taken every cycle when the output is not held off.
// A vector is captured in the parser register at the edge that accepts its last byte.
// The three stages are the parser register, the yaw align register and the
// yaw round register, which is also the output register.
// Reset clears the parser state and all stage valid flags at once.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_packet_field_parser (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               byte_valid,
	output logic              byte_stall,
	input  imupf_pkg::in_t    byte_data,
	output logic              vec_valid,
	input  wire               vec_stall,
	output imupf_pkg::out_t   vec_data
);

	logic adv1, adv2, adv3;
	logic accept;
	logic valid_s1, valid_s2;
	imupf_pkg::parse_t data_s1;
	imupf_pkg::align_t data_s2;

	assign adv3 = !vec_valid || !vec_stall;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign byte_stall = !adv1;
	assign accept = byte_valid && adv1;

	imupf_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.adv      (adv1),
		.byte_in  (byte_data),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	imupf_yaw_align u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv2),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	imupf_yaw_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv3),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_q  (vec_valid),
		.data_q   (vec_data)
	);

	a_stall_full : assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && valid_s2 && vec_valid))
		else $error("input held off while a stage is empty");

	a_s2_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv3) |=> valid_s2)
		else $error("align stage lost an entry while blocked");

	a_out_src : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vec_valid) |-> $past(valid_s2))
		else $error("output became valid without an align entry");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Packet field parser testbench
// Feeds byte streams built from sensor packets, with well-formed, truncated,
// restarted and noisy packets, through the parser under random idling on
// both channels and checks each emitted vector against a local prediction.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	imupf_pkg::in_t byte_data = '0;
	logic vec_valid;
	logic vec_stall = 1'b0;
	imupf_pkg::out_t vec_data;

	imu_packet_field_parser u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.vec_valid(vec_valid),
		.vec_stall(vec_stall),
		.vec_data(vec_data)
	);

	always #1 clk = ~clk;

	imupf_pkg::in_t byte_queue[$];
	imupf_pkg::out_t vector_queue[$];
	int errors = 0;
	int bytes_taken = 0;
	int vectors_seen = 0;
	int yaw_wraps = 0;
	bit stim_done = 1'b0;
	bit quiet_send = 1'b0;
	bit quiet_recv = 1'b0;

	imupf_pkg::hdr_pos_t hdr_pos = imupf_pkg::HP_IDLE;
	imupf_pkg::phase_t phase = imupf_pkg::PH_ID_HI;
	logic [7:0] bytes_left = '0;
	logic [15:0] ident = '0;
	logic [7:0] ident_len = '0;
	logic [7:0] seen = '0;
	logic [31:0] words[3];

	// Exact single precision sum of a negative value and 360, nearest even.
	function automatic logic [31:0] yaw_wrapped(logic [31:0] bits);
		logic [319:0] big, tiny, diff, keep, rem, half;
		logic neg;
		int msb, sh, ex;
		if (!bits[31] || bits[30:0] == 31'd0 || bits[30:23] == imupf_pkg::EXP_MAX)
			return bits;
		big = 320'({1'b1, imupf_pkg::YAW_WRAP_MAG[22:0]})
			<< (imupf_pkg::YAW_WRAP_MAG[30:23] - 1);
		if (bits[30:23] == 8'd0)
			tiny = 320'(bits[22:0]);
		else
			tiny = 320'({1'b1, bits[22:0]}) << (bits[30:23] - 1);
		neg = tiny > big;
		diff = neg ? tiny - big : big - tiny;
		if (diff == '0)
			return 32'd0;
		msb = 0;
		for (int i = 0; i < 320; i++)
			if (diff[i])
				msb = i;
		if (msb <= 23)
			return {neg, diff[30:0]};
		sh = msb - 23;
		keep = diff >> sh;
		rem = diff & ((320'd1 << sh) - 1);
		half = 320'd1 << (sh - 1);
		if (rem > half || (rem == half && keep[0]))
			keep = keep + 1;
		if (keep[24]) begin
			keep = keep >> 1;
			sh++;
		end
		ex = sh + 1;
		return {neg, 8'(ex), keep[22:0]};
	endfunction

	task automatic parse_byte(input imupf_pkg::in_t t);
		imupf_pkg::out_t v;
		int w;
		if (t.frame_start) begin
			hdr_pos = imupf_pkg::HP_H1;
			phase = imupf_pkg::PH_ID_HI;
			return;
		end
		case (hdr_pos)
			imupf_pkg::HP_H1, imupf_pkg::HP_H2: begin
				hdr_pos = imupf_pkg::hdr_pos_t'(hdr_pos + 1);
				return;
			end
			imupf_pkg::HP_H3: begin
				bytes_left = t.data_byte;
				phase = imupf_pkg::PH_ID_HI;
				ident = '0;
				ident_len = '0;
				seen = '0;
				hdr_pos = (t.data_byte != 0) ? imupf_pkg::HP_PAYLOAD : imupf_pkg::HP_IDLE;
				return;
			end
			imupf_pkg::HP_PAYLOAD: ;
			default: begin
				hdr_pos = imupf_pkg::HP_IDLE;
				return;
			end
		endcase
		bytes_left = bytes_left - 8'd1;
		case (phase)
			imupf_pkg::PH_ID_HI: begin
				ident = {t.data_byte, 8'd0};
				phase = imupf_pkg::PH_ID_LO;
			end
			imupf_pkg::PH_ID_LO: begin
				ident[7:0] = t.data_byte;
				phase = imupf_pkg::PH_LEN;
			end
			imupf_pkg::PH_LEN: begin
				ident_len = t.data_byte;
				seen = '0;
				phase = (t.data_byte == 0) ? imupf_pkg::PH_ID_HI : imupf_pkg::PH_DATA;
			end
			default: begin
				if (seen < imupf_pkg::VEC_LEN) begin
					w = seen >> 2;
					words[w] = {words[w][23:0], t.data_byte};
				end
				seen = seen + 8'd1;
				if (seen == ident_len) begin
					if (ident_len == imupf_pkg::VEC_LEN && (ident == imupf_pkg::ID_EULER ||
						ident == imupf_pkg::ID_ACCEL || ident == imupf_pkg::ID_FREEACC ||
						ident == imupf_pkg::ID_GYRO)) begin
						v.vector_kind = (ident == imupf_pkg::ID_EULER) ? imupf_pkg::KIND_EULER :
							(ident == imupf_pkg::ID_ACCEL) ? imupf_pkg::KIND_ACCEL :
							(ident == imupf_pkg::ID_FREEACC) ? imupf_pkg::KIND_FREEACC :
							imupf_pkg::KIND_GYRO;
						v.value_x = words[0];
						v.value_y = words[1];
						v.value_z = (ident == imupf_pkg::ID_EULER) ? yaw_wrapped(words[2])
							: words[2];
						if (v.value_z != words[2])
							yaw_wraps++;
						vector_queue.push_back(v);
					end
					phase = imupf_pkg::PH_ID_HI;
				end
			end
		endcase
		if (bytes_left == 0) begin
			hdr_pos = imupf_pkg::HP_IDLE;
			phase = imupf_pkg::PH_ID_HI;
		end
	endtask

	function automatic int draw_wait(bit quiet);
		return quiet ? 0 : $urandom_range(0, 18);
	endfunction

	int send_wait = 0;
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			byte_valid <= 1'b0;
			send_wait = 0;
		end else begin
			g = send_wait;
			if (byte_valid && !byte_stall) begin
				parse_byte(byte_data);
				bytes_taken++;
				void'(byte_queue.pop_front());
				if ($urandom_range(0, 60) == 0)
					quiet_send = ~quiet_send;
				g = draw_wait(quiet_send);
			end
			if (!(byte_valid && byte_stall)) begin
				if (g == 0 && byte_queue.size() > 0) begin
					byte_valid <= 1'b1;
					byte_data <= byte_queue[0];
				end else begin
					byte_valid <= 1'b0;
					if (g > 0)
						g--;
				end
			end
			send_wait = g;
		end
	end

	// A long receiver hold-off, timed in its own process, so that the block fills up.
	int hold_count = 0;
	bit hold_on = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_count = 0;
			hold_on <= 1'b0;
		end else begin
			hold_count++;
			hold_on <= (hold_count >= 300 && hold_count < 1800);
		end
	end

	int recv_wait = 0;
	always @(posedge clk or negedge arst_n) begin
		imupf_pkg::out_t e;
		if (!arst_n) begin
			vec_stall <= 1'b0;
			recv_wait = 0;
		end else begin
			if (vec_valid && !vec_stall) begin
				vectors_seen++;
				if (vector_queue.size() == 0) begin
					$error("unexpected transaction: kind %0d x %h y %h z %h",
						vec_data.vector_kind, vec_data.value_x, vec_data.value_y,
						vec_data.value_z);
					errors++;
				end else begin
					e = vector_queue.pop_front();
					if (vec_data.vector_kind !== e.vector_kind) begin
						$error("vector_kind expected %0d actual %0d", e.vector_kind,
							vec_data.vector_kind);
						errors++;
					end
					if (vec_data.value_x !== e.value_x) begin
						$error("value_x expected %h actual %h", e.value_x, vec_data.value_x);
						errors++;
					end
					if (vec_data.value_y !== e.value_y) begin
						$error("value_y expected %h actual %h", e.value_y, vec_data.value_y);
						errors++;
					end
					if (vec_data.value_z !== e.value_z) begin
						$error("value_z expected %h actual %h", e.value_z, vec_data.value_z);
						errors++;
					end
				end
				if ($urandom_range(0, 8) == 0)
					quiet_recv = ~quiet_recv;
				recv_wait = draw_wait(quiet_recv);
			end
			if (recv_wait > 0) begin
				vec_stall <= 1'b1;
				recv_wait--;
			end else begin
				vec_stall <= hold_on;
			end
		end
	end

	task automatic put(input logic [7:0] b, input bit fs = 1'b0);
		imupf_pkg::in_t t;
		t.data_byte = b;
		t.frame_start = fs;
		byte_queue.push_back(t);
	endtask

	function automatic logic [31:0] pick_word(bit neg);
		logic [31:0] w;
		case ($urandom_range(0, 7))
			0: w = 32'h7F80_0000;
			1: w = 32'h7FC0_0001;
			2: w = 32'h0000_0000;
			3: w = {1'b0, 8'($urandom_range(0, 3)), 23'($urandom)};
			4: w = {1'b0, 8'($urandom_range(120, 140)), 23'($urandom)};
			5: w = {1'b0, 8'h87, 23'h34_0000 + 23'($urandom_range(0, 2)) - 23'd1};
			default: w = $urandom;
		endcase
		if (neg)
			w[31] = 1'b1;
		return w;
	endfunction

	task automatic build_packet();
		logic [7:0] pl[$];
		logic [15:0] id;
		logic [31:0] w;
		int n, len, plen;
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: id = imupf_pkg::ID_EULER;
				1, 2: id = imupf_pkg::ID_EULER;
				3: id = imupf_pkg::ID_ACCEL;
				4: id = imupf_pkg::ID_FREEACC;
				5: id = imupf_pkg::ID_GYRO;
				6: id = 16'($urandom);
				default: id = {$urandom_range(0, 1) ? imupf_pkg::ID_ACCEL[15:8] : 8'($urandom),
					8'($urandom)};
			endcase
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : 12;
			pl.push_back(id[15:8]);
			pl.push_back(id[7:0]);
			pl.push_back(8'(len));
			for (int c = 0; c < len; c += 4) begin
				w = pick_word(c == 8 && $urandom_range(0, 2) != 0);
				for (int k = 0; k < 4 && c + k < len; k++)
					pl.push_back(w[31 - 8*k -: 8]);
			end
		end
		plen = pl.size();
		case ($urandom_range(0, 11))
			0: plen = $urandom_range(0, plen);
			1: plen = 0;
			default: ;
		endcase
		put(8'hFA, 1'b1);
		put(8'hFF);
		put(8'h36);
		put(8'(plen));
		if ($urandom_range(0, 15) == 0)
			n = $urandom_range(0, pl.size());
		else
			n = pl.size();
		for (int i = 0; i < n; i++)
			put(pl[i]);
		if (n < pl.size()) begin
			put(8'hFA, 1'b1);
			return;
		end
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++)
			put(8'($urandom));
	endtask

	initial begin
		int cycles;
		// Stray bytes, an empty packet, then one Euler packet with a negative yaw.
		put(8'h00);
		put(8'hFF);
		put(8'hFA, 1'b1);
		put(8'hFF);
		put(8'h36);
		put(8'h00);
		put(8'hFA, 1'b1);
		put(8'hFF);
		put(8'h36);
		put(8'd15);
		put(imupf_pkg::ID_EULER[15:8]);
		put(imupf_pkg::ID_EULER[7:0]);
		put(imupf_pkg::VEC_LEN);
		put(8'h7F); put(8'h7F); put(8'hFF); put(8'hFF);
		put(8'h00); put(8'h00); put(8'h00); put(8'h01);
		put(8'hBF); put(8'h80); put(8'h00); put(8'h00);
		while (byte_queue.size() < 1300)
			build_packet();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (byte_queue.size() == 0 && !byte_valid);
		wait (vector_queue.size() == 0);
		repeat (10) @(posedge clk);
		$display("Sent %0d bytes and checked %0d vectors, %0d with a wrapped yaw.",
			bytes_taken, vectors_seen, yaw_wraps);
		if (errors == 0)
			$display("imu_packet_field_parser: match");
		else
			$display("imu_packet_field_parser: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("imu_packet_field_parser: mismatch");
		$finish;
	end
endmodule

FILE: files.f
rtl/imupf_pkg.sv
rtl/imupf_parser.sv
rtl/imupf_yaw_align.sv
rtl/imupf_yaw_round.sv
rtl/imu_packet_field_parser.sv
tb/testbench.sv
